FILE: hw/rtl/glyph_to_word_segmenter_defines.svh
// Assertion macros for the glyph-to-word segmenter checker.
// No dependencies; included by files that carry assertions.
`ifndef GLYPH_TO_WORD_SEGMENTER_DEFINES_SVH
`define GLYPH_TO_WORD_SEGMENTER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define GWS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define GWS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/gws_pkg.sv
// Shared constants, codes and item types of the glyph-to-word segmenter.
// No dependencies; used by the interfaces and all modules.
package gws_pkg;

  localparam int COORD_BITS = 16;
  localparam int COUNT_BITS = 8;
  localparam int FONT_BITS  = 12;
  localparam int ROT_BITS   = 2;
  localparam int QBITS      = 8;
  localparam int BS_W       = 8;
  localparam int RATIO_W    = 9;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam int GAP_W   = COORD_BITS + 1;
  localparam int LIM_W   = BS_W + FONT_BITS;
  localparam int PROD_W  = COORD_BITS + RATIO_W;
  localparam int CMP_W   = (COORD_BITS + QBITS > LIM_W) ? COORD_BITS + QBITS : LIM_W;

  localparam logic [BS_W-1:0]       BREAK_SPACE_RESET   = BS_W'(38);
  localparam logic [RATIO_W-1:0]    OVERLAP_RATIO_RESET = RATIO_W'(128);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX           = {COUNT_BITS{1'b1}};

  localparam logic CMD_GLYPH = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic {
    REG_BREAK_SPACE   = 1'b0,
    REG_OVERLAP_RATIO = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] max_y;
    logic [FONT_BITS-1:0]  font_size;
    logic                  writing_mode;
    logic [ROT_BITS-1:0]   rotation;
    logic                  is_diacritic;
  } glyph_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] max_y;
    logic [FONT_BITS-1:0]  font_size;
    logic                  writing_mode;
    logic [ROT_BITS-1:0]   rotation;
    logic [COUNT_BITS-1:0] count;
  } word_t;

endpackage

FILE: hw/rtl/gws_glyph_if.sv
// Glyph input channel: valid/ready handshake plus one glyph item.
// Depends on gws_pkg.
interface gws_glyph_if;
  import gws_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [COORD_BITS-1:0] min_x;
  logic [COORD_BITS-1:0] min_y;
  logic [COORD_BITS-1:0] max_x;
  logic [COORD_BITS-1:0] max_y;
  logic [FONT_BITS-1:0]  font_size;
  logic                  writing_mode;
  logic [ROT_BITS-1:0]   rotation;
  logic                  is_diacritic;

  modport source (
    output valid, command, min_x, min_y, max_x, max_y, font_size,
           writing_mode, rotation, is_diacritic,
    input  ready
  );

  modport sink (
    input  valid, command, min_x, min_y, max_x, max_y, font_size,
           writing_mode, rotation, is_diacritic,
    output ready
  );
endinterface

FILE: hw/rtl/gws_word_if.sv
// Word output channel: valid/ready handshake plus one closed word item.
// Depends on gws_pkg.
interface gws_word_if;
  import gws_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] word_min_x;
  logic [COORD_BITS-1:0] word_min_y;
  logic [COORD_BITS-1:0] word_max_x;
  logic [COORD_BITS-1:0] word_max_y;
  logic [FONT_BITS-1:0]  word_font_size;
  logic                  word_writing_mode;
  logic [ROT_BITS-1:0]   word_rotation;
  logic [COUNT_BITS-1:0] glyph_count;

  modport source (
    output valid, word_min_x, word_min_y, word_max_x, word_max_y, word_font_size,
           word_writing_mode, word_rotation, glyph_count,
    input  ready
  );

  modport sink (
    input  valid, word_min_x, word_min_y, word_max_x, word_max_y, word_font_size,
           word_writing_mode, word_rotation, glyph_count,
    output ready
  );
endinterface

FILE: hw/rtl/gws_break_unit.sv
// Word-break decision for one glyph against the open word: mode/rotation
// change, overlap ratio across the line, gap along the line. Depends on gws_pkg.
module gws_break_unit (
  input  gws_pkg::glyph_t             glyph,
  input  gws_pkg::word_t              word_box,
  input  logic [gws_pkg::BS_W-1:0]    break_space_q8,
  input  logic [gws_pkg::RATIO_W-1:0] overlap_ratio_q8,
  output logic                        brk
);
  import gws_pkg::*;

  logic [COORD_BITS-1:0] al_g0, al_g1, al_w0, al_w1;
  logic [COORD_BITS-1:0] ac_g0, ac_g1, ac_w0, ac_w1;
  logic [COORD_BITS-1:0] span_hi, span_lo, overlap;
  logic signed [GAP_W-1:0] gap_a, gap_b, ovl_raw, h_word, h_glyph;
  logic [LIM_W-1:0]  limit;
  logic [PROD_W-1:0] ovl_scaled, rhs_word, rhs_glyph;
  logic gap_a_brk, gap_b_brk, under_word, under_glyph, style_brk;

  always_comb begin
    if (glyph.rotation[0]) begin
      al_g0 = glyph.min_y;    al_g1 = glyph.max_y;
      al_w0 = word_box.min_y; al_w1 = word_box.max_y;
      ac_g0 = glyph.min_x;    ac_g1 = glyph.max_x;
      ac_w0 = word_box.min_x; ac_w1 = word_box.max_x;
    end else begin
      al_g0 = glyph.min_x;    al_g1 = glyph.max_x;
      al_w0 = word_box.min_x; al_w1 = word_box.max_x;
      ac_g0 = glyph.min_y;    ac_g1 = glyph.max_y;
      ac_w0 = word_box.min_y; ac_w1 = word_box.max_y;
    end
  end

  assign gap_a = signed'({1'b0, al_g0}) - signed'({1'b0, al_w1});
  assign gap_b = signed'({1'b0, al_w0}) - signed'({1'b0, al_g1});

  assign span_hi = (ac_w1 < ac_g1) ? ac_w1 : ac_g1;
  assign span_lo = (ac_w0 > ac_g0) ? ac_w0 : ac_g0;
  assign ovl_raw = signed'({1'b0, span_hi}) - signed'({1'b0, span_lo});
  assign overlap = ovl_raw[GAP_W-1] ? '0 : ovl_raw[COORD_BITS-1:0];

  assign h_word  = signed'({1'b0, ac_w1}) - signed'({1'b0, ac_w0});
  assign h_glyph = signed'({1'b0, ac_g1}) - signed'({1'b0, ac_g0});

  assign ovl_scaled = PROD_W'({overlap, {QBITS{1'b0}}});
  assign rhs_word   = PROD_W'(overlap_ratio_q8) * PROD_W'(h_word[COORD_BITS-1:0]);
  assign rhs_glyph  = PROD_W'(overlap_ratio_q8) * PROD_W'(h_glyph[COORD_BITS-1:0]);

  assign under_word  = (h_word[GAP_W-1] || h_word == '0) ? (overlap_ratio_q8 != '0)
                                                         : (ovl_scaled < rhs_word);
  assign under_glyph = (h_glyph[GAP_W-1] || h_glyph == '0) ? (overlap_ratio_q8 != '0)
                                                           : (ovl_scaled < rhs_glyph);

  assign limit = LIM_W'(break_space_q8) * LIM_W'(word_box.font_size);

  assign gap_a_brk = !gap_a[GAP_W-1] &&
                     (CMP_W'({gap_a[COORD_BITS-1:0], {QBITS{1'b0}}}) > CMP_W'(limit));
  assign gap_b_brk = !gap_b[GAP_W-1] &&
                     (CMP_W'({gap_b[COORD_BITS-1:0], {QBITS{1'b0}}}) > CMP_W'(limit));

  assign style_brk = (glyph.writing_mode != word_box.writing_mode) ||
                     (glyph.rotation != word_box.rotation);

  assign brk = style_brk || (under_word && under_glyph) || gap_a_brk || gap_b_brk;

endmodule

FILE: hw/rtl/glyph_to_word_segmenter.sv
// Glyph-to-word segmenter top level: channels, register port, word state.
// Depends on gws_pkg, gws_glyph_if, gws_word_if and gws_break_unit.
//
// Usage:
//   glyph  : glyph items in extraction order; command selects glyph or
//            end-of-page flush. Diacritic glyph items are dropped.
//   word   : one item per closed word (box, largest font, mode, rotation,
//            saturating glyph count). A word closes when a glyph breaks it
//            or on a flush; a flush with no open word gives nothing.
//   APB    : break_space_q8 at 0x0, overlap_ratio_q8 at 0x4; write only
//            while idle. Reads return the register value, pready is tied high.
// Throughput: one item per cycle while the word sink keeps up. Each item
//   sits in the input register, then one compare/multiply pass against the
//   word state loads the result register; a closed word shows on the word
//   channel once the item that closed it has passed the input register.
// Reset: no word open, registers at 38 and 128, both channels empty.
// Stall: the result register holds; the input register takes one more item,
//   then glyph.ready drops until the word sink takes the result.
module glyph_to_word_segmenter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gws_pkg::ADDR_W-1:0] paddr,
  input  logic [gws_pkg::DATA_W-1:0] pwdata,
  output logic [gws_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  gws_glyph_if.sink                  glyph,
  gws_word_if.source                 word
);
  import gws_pkg::*;

  logic [BS_W-1:0]    break_space_q8;
  logic [RATIO_W-1:0] overlap_ratio_q8;

  glyph_t s1_glyph;
  logic   s1_valid;
  logic   s1_adv;

  word_t  word_box, word_box_next;
  logic   word_open, word_open_next;
  word_t  res;
  logic   res_valid;
  logic   emit;
  logic   brk;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1]);

  always_comb begin
    unique case (reg_idx)
      REG_BREAK_SPACE:   prdata = DATA_W'(break_space_q8);
      REG_OVERLAP_RATIO: prdata = DATA_W'(overlap_ratio_q8);
      default:           prdata = '0;
    endcase
  end

  assign s1_adv      = s1_valid && (!res_valid || word.ready);
  assign glyph.ready = !s1_valid || s1_adv;

  gws_break_unit u_break (
    .glyph            (s1_glyph),
    .word_box         (word_box),
    .break_space_q8   (break_space_q8),
    .overlap_ratio_q8 (overlap_ratio_q8),
    .brk              (brk)
  );

  always_comb begin
    emit           = 1'b0;
    word_open_next = word_open;
    word_box_next  = word_box;
    if (s1_glyph.command == CMD_FLUSH) begin
      if (word_open) begin
        emit           = 1'b1;
        word_open_next = 1'b0;
      end
    end else if (!s1_glyph.is_diacritic) begin
      if (!word_open || brk) begin
        emit                       = word_open;
        word_open_next             = 1'b1;
        word_box_next.min_x        = s1_glyph.min_x;
        word_box_next.min_y        = s1_glyph.min_y;
        word_box_next.max_x        = s1_glyph.max_x;
        word_box_next.max_y        = s1_glyph.max_y;
        word_box_next.font_size    = s1_glyph.font_size;
        word_box_next.writing_mode = s1_glyph.writing_mode;
        word_box_next.rotation     = s1_glyph.rotation;
        word_box_next.count        = COUNT_BITS'(1);
      end else begin
        if (s1_glyph.min_x < word_box.min_x) word_box_next.min_x = s1_glyph.min_x;
        if (s1_glyph.min_y < word_box.min_y) word_box_next.min_y = s1_glyph.min_y;
        if (s1_glyph.max_x > word_box.max_x) word_box_next.max_x = s1_glyph.max_x;
        if (s1_glyph.max_y > word_box.max_y) word_box_next.max_y = s1_glyph.max_y;
        if (s1_glyph.font_size > word_box.font_size) begin
          word_box_next.font_size = s1_glyph.font_size;
        end
        if (word_box.count != COUNT_MAX) word_box_next.count = word_box.count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      break_space_q8   <= BREAK_SPACE_RESET;
      overlap_ratio_q8 <= OVERLAP_RATIO_RESET;
      s1_valid         <= 1'b0;
      word_open        <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (reg_idx)
          REG_BREAK_SPACE:   break_space_q8   <= pwdata[BS_W-1:0];
          REG_OVERLAP_RATIO: overlap_ratio_q8 <= pwdata[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (glyph.ready) begin
        s1_valid <= glyph.valid;
      end
      if (s1_adv) begin
        word_open <= word_open_next;
      end
      res_valid <= (s1_adv && emit) || (res_valid && !word.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (glyph.valid && glyph.ready) begin
      s1_glyph.command      <= glyph.command;
      s1_glyph.min_x        <= glyph.min_x;
      s1_glyph.min_y        <= glyph.min_y;
      s1_glyph.max_x        <= glyph.max_x;
      s1_glyph.max_y        <= glyph.max_y;
      s1_glyph.font_size    <= glyph.font_size;
      s1_glyph.writing_mode <= glyph.writing_mode;
      s1_glyph.rotation     <= glyph.rotation;
      s1_glyph.is_diacritic <= glyph.is_diacritic;
    end
    if (s1_adv) begin
      word_box <= word_box_next;
    end
    if (s1_adv && emit) begin
      res <= word_box;
    end
  end

  assign word.valid             = res_valid;
  assign word.word_min_x        = res.min_x;
  assign word.word_min_y        = res.min_y;
  assign word.word_max_x        = res.max_x;
  assign word.word_max_y        = res.max_y;
  assign word.word_font_size    = res.font_size;
  assign word.word_writing_mode = res.writing_mode;
  assign word.word_rotation     = res.rotation;
  assign word.glyph_count       = res.count;

endmodule

FILE: hw/rtl/gws_checker.sv
// Port-level assertions for the glyph-to-word segmenter, bound to the top.
// Depends on gws_pkg and glyph_to_word_segmenter_defines.svh.
`include "glyph_to_word_segmenter_defines.svh"

module gws_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           glyph_valid,
  input logic                           glyph_ready,
  input logic                           word_valid,
  input logic                           word_ready,
  input logic [gws_pkg::COUNT_BITS-1:0] glyph_count
);
  import gws_pkg::*;

  `GWS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !word_valid, "word valid after reset")
  `GWS_ASSERT(a_word_holds, clk, rst, word_valid && !word_ready |=> word_valid, "word dropped")
  `GWS_ASSERT(a_count_nonzero, clk, rst, word_valid |-> glyph_count != '0, "empty word")
  `GWS_ASSERT(a_word_has_cause, clk, rst, $rose(word_valid) |-> $past(glyph_valid && glyph_ready, 2), "word without item")

endmodule

bind glyph_to_word_segmenter gws_checker u_gws_checker (
  .clk         (clk),
  .rst         (rst),
  .glyph_valid (glyph.valid),
  .glyph_ready (glyph.ready),
  .word_valid  (word.valid),
  .word_ready  (word.ready),
  .glyph_count (word.glyph_count)
);

FILE: dv/glyph_to_word_segmenter_test.sv
// Testbench for glyph_to_word_segmenter: directed, saturation, stall and random traffic.
// Predicts every closed word and checks each word item field by field.
// Depends on gws_pkg, gws_glyph_if, gws_word_if and the glyph_to_word_segmenter RTL.
module glyph_to_word_segmenter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gws_pkg::*;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  gws_glyph_if glyph_ch ();
  gws_word_if  word_ch ();

  glyph_to_word_segmenter dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .glyph   (glyph_ch),
    .word    (word_ch)
  );

  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_left;
  int mismatch_count;

  logic [BS_W-1:0]    cfg_break_space;
  logic [RATIO_W-1:0] cfg_overlap_ratio;
  bit                 word_open;
  word_t              building_word;
  word_t              expected_words[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("glyph_to_word_segmenter: mismatch");
    $finish;
  end

  task automatic report_mismatch(string what, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected %0h, got %0h at %0t", what, want, got, $realtime);
  endtask

  function automatic bit below_ratio(longint overlap, longint height);
    if (height <= 0) return cfg_overlap_ratio != 0;
    return overlap * 256 < longint'(cfg_overlap_ratio) * height;
  endfunction

  task automatic start_word(glyph_t g);
    word_open                  = 1'b1;
    building_word.min_x        = g.min_x;
    building_word.min_y        = g.min_y;
    building_word.max_x        = g.max_x;
    building_word.max_y        = g.max_y;
    building_word.font_size    = g.font_size;
    building_word.writing_mode = g.writing_mode;
    building_word.rotation     = g.rotation;
    building_word.count        = COUNT_BITS'(1);
  endtask

  task automatic segment_glyph(glyph_t g);
    longint ga0, ga1, gc0, gc1, wa0, wa1, wc0, wc1;
    longint gap_a, gap_b, overlap, lo, hi, lim;
    bit brk;
    if (g.command == CMD_FLUSH) begin
      if (word_open) begin
        expected_words = {expected_words, building_word};
        word_open = 1'b0;
      end
      return;
    end
    if (g.is_diacritic) return;
    if (!word_open) begin
      start_word(g);
      return;
    end
    if (g.writing_mode != building_word.writing_mode ||
        g.rotation != building_word.rotation) begin
      brk = 1'b1;
    end else begin
      if (!g.rotation[0]) begin
        ga0 = g.min_x; ga1 = g.max_x; gc0 = g.min_y; gc1 = g.max_y;
        wa0 = building_word.min_x; wa1 = building_word.max_x;
        wc0 = building_word.min_y; wc1 = building_word.max_y;
      end else begin
        ga0 = g.min_y; ga1 = g.max_y; gc0 = g.min_x; gc1 = g.max_x;
        wa0 = building_word.min_y; wa1 = building_word.max_y;
        wc0 = building_word.min_x; wc1 = building_word.max_x;
      end
      gap_a = ga0 - wa1;
      gap_b = wa0 - ga1;
      lo = (wc0 > gc0) ? wc0 : gc0;
      hi = (wc1 < gc1) ? wc1 : gc1;
      overlap = (hi - lo > 0) ? hi - lo : 0;
      lim = longint'(cfg_break_space) * longint'(building_word.font_size);
      brk = (below_ratio(overlap, gc1 - gc0) && below_ratio(overlap, wc1 - wc0)) ||
            gap_a * 256 > lim || gap_b * 256 > lim;
    end
    if (brk) begin
      expected_words = {expected_words, building_word};
      start_word(g);
      return;
    end
    if (g.min_x < building_word.min_x) building_word.min_x = g.min_x;
    if (g.min_y < building_word.min_y) building_word.min_y = g.min_y;
    if (g.max_x > building_word.max_x) building_word.max_x = g.max_x;
    if (g.max_y > building_word.max_y) building_word.max_y = g.max_y;
    if (g.font_size > building_word.font_size) building_word.font_size = g.font_size;
    if (building_word.count != COUNT_MAX) building_word.count++;
  endtask

  function automatic glyph_t glyph_item(logic cmd, int x0, int y0, int x1, int y1,
                                        int font, int mode, int rot, int diac);
    glyph_t g;
    g.command      = cmd;
    g.min_x        = COORD_BITS'(x0);
    g.min_y        = COORD_BITS'(y0);
    g.max_x        = COORD_BITS'(x1);
    g.max_y        = COORD_BITS'(y1);
    g.font_size    = FONT_BITS'(font);
    g.writing_mode = 1'(mode);
    g.rotation     = ROT_BITS'(rot);
    g.is_diacritic = 1'(diac);
    return g;
  endfunction

  function automatic glyph_t random_item();
    return glyph_item(($urandom_range(3) == 0) ? CMD_FLUSH : CMD_GLYPH,
                      $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
  endfunction

  task automatic send_item(glyph_t g);
    while ($urandom_range(99) < send_idle_pct) begin
      glyph_ch.valid <= 1'b0;
      @(negedge clk);
    end
    glyph_ch.valid        <= 1'b1;
    glyph_ch.command      <= g.command;
    glyph_ch.min_x        <= g.min_x;
    glyph_ch.min_y        <= g.min_y;
    glyph_ch.max_x        <= g.max_x;
    glyph_ch.max_y        <= g.max_y;
    glyph_ch.font_size    <= g.font_size;
    glyph_ch.writing_mode <= g.writing_mode;
    glyph_ch.rotation     <= g.rotation;
    glyph_ch.is_diacritic <= g.is_diacritic;
    do @(posedge clk); while (!glyph_ch.ready);
    segment_glyph(g);
    @(negedge clk);
  endtask

  // drop valid, wait for every predicted word, then let the pipeline empty
  task automatic settle();
    glyph_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, int unsigned value);
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] stored;
    mask   = (idx == REG_BREAK_SPACE) ? (1 << BS_W) - 1 : (1 << RATIO_W) - 1;
    stored = value & mask;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= ($urandom & ~mask) | stored;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_BREAK_SPACE) cfg_break_space = stored[BS_W-1:0];
    else cfg_overlap_ratio = stored[RATIO_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) report_mismatch("register readback", stored, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed_cases();
    glyph_t items[$];
    items = '{
      glyph_item(CMD_FLUSH, 5, 5, 9, 9, 100, 0, 0, 1),
      glyph_item(CMD_GLYPH, 10, 10, 20, 20, 100, 0, 0, 1),
      glyph_item(CMD_GLYPH, 0, 0, 100, 160, 160, 0, 0, 0),
      glyph_item(CMD_GLYPH, 110, 10, 200, 170, 200, 0, 0, 0),
      glyph_item(CMD_GLYPH, 60000, 60000, 61000, 61000, 160, 0, 0, 1),
      glyph_item(CMD_GLYPH, 260, 0, 360, 160, 160, 0, 0, 0),
      glyph_item(CMD_GLYPH, 0, 0, 100, 160, 160, 0, 0, 0),
      glyph_item(CMD_GLYPH, 105, 150, 200, 310, 160, 0, 0, 0),
      glyph_item(CMD_GLYPH, 105, 150, 200, 310, 160, 0, 2, 0),
      glyph_item(CMD_GLYPH, 105, 150, 200, 310, 160, 1, 2, 0),
      glyph_item(CMD_GLYPH, 0, 0, 160, 100, 160, 0, 1, 0),
      glyph_item(CMD_GLYPH, 0, 105, 160, 200, 160, 0, 1, 0),
      glyph_item(CMD_GLYPH, 150, 210, 300, 300, 160, 0, 1, 0),
      glyph_item(CMD_GLYPH, 150, 210, 300, 300, 160, 0, 3, 0),
      glyph_item(CMD_GLYPH, 200, 300, 200, 400, 160, 0, 3, 0),
      glyph_item(CMD_GLYPH, 500, 500, 400, 400, 160, 0, 0, 0),
      glyph_item(CMD_GLYPH, 400, 400, 500, 500, 160, 0, 0, 0),
      glyph_item(CMD_GLYPH, 65535, 65535, 65535, 65535, 4095, 1, 3, 0),
      glyph_item(CMD_GLYPH, 0, 0, 0, 0, 0, 1, 3, 0),
      glyph_item(CMD_FLUSH, 65535, 65535, 65535, 65535, 4095, 1, 3, 1),
      glyph_item(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0),
      glyph_item(CMD_GLYPH, 65535, 0, 65535, 65535, 4095, 1, 3, 0),
      glyph_item(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0)
    };
    foreach (items[i]) send_item(items[i]);
    settle();
  endtask

  task automatic test_count_saturation();
    for (int i = 0; i < 300; i++)
      send_item(glyph_item(CMD_GLYPH, 1000, 1000, 1100, 1160, 160 + i % 7, 0, 0, 0));
    send_item(glyph_item(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0));
    settle();
  endtask

  task automatic test_output_stall();
    glyph_ch.valid <= 1'b0;
    @(posedge clk);
    hold_off_left = 200;
    @(negedge clk);
    for (int i = 0; i < 40; i++)
      send_item(glyph_item(CMD_GLYPH, 10 * i, 0, 10 * i + 8, 160, 160, 0, i % 4, 0));
    send_item(glyph_item(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0));
    settle();
  endtask

  // one line of glyphs with random spacing, jitter and occasional odd boxes
  task automatic send_line(inout int counted);
    int mode, rot, font, h, across, along, n, w, gap, jit, hh, c0, c1, a0, a1, sel;
    glyph_t g;
    mode   = $urandom_range(1);
    rot    = $urandom_range(3);
    font   = ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(64, 400);
    h      = $urandom_range(8, 400);
    across = $urandom_range(64000);
    along  = $urandom_range(60000);
    n      = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      w   = $urandom_range(200);
      sel = $urandom_range(19);
      if (sel == 0) gap = $urandom_range(600);
      else if (sel == 1) gap = -int'($urandom_range(100));
      else gap = $urandom_range(font / 4 + 1);
      if ($urandom_range(5) == 0) jit = int'($urandom_range(2 * h)) - h;
      else jit = int'($urandom_range(h / 4)) - h / 8;
      hh = ($urandom_range(19) == 0) ? 0 : h;
      c0 = across + jit;
      c1 = c0 + hh;
      a0 = along + gap;
      a1 = a0 + w;
      if ($urandom_range(19) == 0) begin
        c0 = c1;
        c1 = across + jit;
      end
      if (rot[0]) g = glyph_item(CMD_GLYPH, c0, a0, c1, a1, font, mode, rot, 0);
      else g = glyph_item(CMD_GLYPH, a0, c0, a1, c1, font, mode, rot, 0);
      sel = $urandom_range(99);
      if (sel < 5) g.writing_mode = ~g.writing_mode;
      else if (sel < 10) g.rotation = ROT_BITS'($urandom);
      else if (sel < 16) g.is_diacritic = 1'b1;
      if ($urandom_range(9) == 0) g.font_size = FONT_BITS'($urandom);
      send_item(g);
      if (!g.is_diacritic) counted++;
      along = a1;
    end
    if ($urandom_range(2) == 0) begin
      g = random_item();
      g.command = CMD_FLUSH;
      send_item(g);
      counted++;
    end
  endtask

  task automatic test_random_traffic(int target, int break_space, int overlap_ratio);
    int counted;
    glyph_t g;
    counted = 0;
    write_register(REG_BREAK_SPACE, break_space);
    write_register(REG_OVERLAP_RATIO, overlap_ratio);
    while (counted < target) begin
      if ($urandom_range(7) == 0) begin
        g = random_item();
        send_item(g);
        if (g.command == CMD_FLUSH || !g.is_diacritic) counted++;
      end else begin
        send_line(counted);
      end
    end
    settle();
  endtask

  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      word_ch.ready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      word_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) report_mismatch(name, want, got);
  endtask

  always @(posedge clk) begin
    word_t want;
    if (!rst && word_ch.valid && word_ch.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word item, glyph_count", 0, word_ch.glyph_count);
      end else begin
        want = expected_words.pop_front();
        compare_field("word_min_x", want.min_x, word_ch.word_min_x);
        compare_field("word_min_y", want.min_y, word_ch.word_min_y);
        compare_field("word_max_x", want.max_x, word_ch.word_max_x);
        compare_field("word_max_y", want.max_y, word_ch.word_max_y);
        compare_field("word_font_size", want.font_size, word_ch.word_font_size);
        compare_field("word_writing_mode", want.writing_mode, word_ch.word_writing_mode);
        compare_field("word_rotation", want.rotation, word_ch.word_rotation);
        compare_field("glyph_count", want.count, word_ch.glyph_count);
      end
    end
  end

  initial begin
    int bs_vals[6];
    int ratio_vals[6];
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    glyph_ch.valid        = 1'b0;
    glyph_ch.command      = CMD_GLYPH;
    glyph_ch.min_x        = '0;
    glyph_ch.min_y        = '0;
    glyph_ch.max_x        = '0;
    glyph_ch.max_y        = '0;
    glyph_ch.font_size    = '0;
    glyph_ch.writing_mode = 1'b0;
    glyph_ch.rotation     = '0;
    glyph_ch.is_diacritic = 1'b0;
    word_ch.ready         = 1'b0;
    hold_off_left         = 0;
    mismatch_count        = 0;
    word_open             = 1'b0;
    building_word         = '0;
    cfg_break_space       = BREAK_SPACE_RESET;
    cfg_overlap_ratio     = OVERLAP_RATIO_RESET;
    send_idle_pct         = 32;
    recv_idle_pct         = 73;
    bs_vals    = '{0, 255, 38, 128, $urandom_range(255), 255};
    ratio_vals = '{0, 256, 128, 511, $urandom_range(256), 300};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    send_idle_pct = 73;
    recv_idle_pct = 32;
    test_count_saturation();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();

    for (int phase = 0; phase < 6; phase++) begin
      send_idle_pct = (phase < 2) ? 32 : (phase < 4) ? 73 : 0;
      recv_idle_pct = (phase < 2) ? 73 : (phase < 4) ? 32 : 0;
      test_random_traffic(180, bs_vals[phase], ratio_vals[phase]);
    end

    settle();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("glyph_to_word_segmenter: match");
    end else begin
      $display("glyph_to_word_segmenter: mismatch");
    end
    $finish;
  end

endmodule
